/* rtl/core/sphere_mesh_triangle_generator_defines.svh */
//------------------------------------------------------------------------------
// sphere mesh triangle generator assertion macros
// shared concurrent assertion forms, clocked on the rising edge
//------------------------------------------------------------------------------
`ifndef SPHERE_MESH_TRIANGLE_GENERATOR_DEFINES_SVH
`define SPHERE_MESH_TRIANGLE_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SMTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SMTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/smtg_pkg.sv */
//------------------------------------------------------------------------------
// smtg package
// shared constants, types and cordic helpers of the sphere mesh generator
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package smtg_pkg;

    localparam int MAX_STEPS     = 256;
    localparam int CORDIC_STAGES = 16;
    localparam int STEPS_W       = 9;
    localparam int PH_W          = 32;
    localparam int DIV_CELLS     = PH_W;

    localparam logic [2:0] LAST_SLOT = 3'd5;

    // register indexes of the configuration port
    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_CENTER_X = 3'd1;
    localparam logic [2:0] REG_CENTER_Y = 3'd2;
    localparam logic [2:0] REG_CENTER_Z = 3'd3;
    localparam logic [2:0] REG_THETA    = 3'd4;
    localparam logic [2:0] REG_PHI      = 3'd5;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

    typedef struct packed {
        logic       valid;
        logic       bad;
        logic [2:0] slot;
    } t_tag;

    // fractional long division state for both angles
    typedef struct packed {
        logic               hi_p;
        logic               hi_t;
        logic [STEPS_W-1:0] rem_p;
        logic [STEPS_W-1:0] rem_t;
        logic [PH_W-1:0]    q_p;
        logic [PH_W-1:0]    q_t;
    } t_div;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_rot;

    typedef struct packed {
        t_rot       p;
        t_rot       t;
        logic [1:0] quad_p;
        logic [1:0] quad_t;
    } t_cor;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // one rotation-mode micro-rotation
    function automatic t_rot rot_step(input t_rot v, input logic [4:0] s);
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] at;
        t_rot               r;
        dx = v.y >>> s;
        dy = v.x >>> s;
        at = signed'(atan_turn(s));
        if (!v.z[31]) begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - at;
        end else begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + at;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            r = -ONE_Q30;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/core/smtg_div_cell.sv */
//------------------------------------------------------------------------------
// smtg divider cell
// one restoring step of the angle phase division, both angles in parallel
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module smtg_div_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  smtg_pkg::t_tag                      i_tag,
    input  smtg_pkg::t_div                      i_div,
    input  logic [smtg_pkg::STEPS_W-1:0]        i_den_p,
    input  logic [smtg_pkg::STEPS_W-1:0]        i_den_t,
    output smtg_pkg::t_tag                      o_tag,
    output smtg_pkg::t_div                      o_div
);
    import smtg_pkg::*;

    logic [STEPS_W:0] n2_p;
    logic [STEPS_W:0] n2_t;
    logic             ge_p;
    logic             ge_t;
    t_div             n_div;
    t_div             r_div;
    t_tag             r_tag;

    always_comb begin
        n2_p = {i_div.rem_p, 1'b0};
        n2_t = {i_div.rem_t, 1'b0};
        ge_p = n2_p >= {1'b0, i_den_p};
        ge_t = n2_t >= {1'b0, i_den_t};
        n_div = i_div;
        n_div.rem_p = ge_p ? STEPS_W'(n2_p - {1'b0, i_den_p}) : n2_p[STEPS_W-1:0];
        n_div.rem_t = ge_t ? STEPS_W'(n2_t - {1'b0, i_den_t}) : n2_t[STEPS_W-1:0];
        n_div.q_p = {i_div.q_p[PH_W-2:0], ge_p};
        n_div.q_t = {i_div.q_t[PH_W-2:0], ge_t};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_tag = r_tag;
    assign o_div = r_div;

endmodule

/* rtl/core/smtg_cordic_cell.sv */
//------------------------------------------------------------------------------
// smtg cordic cell
// one micro-rotation for the polar and the azimuth angle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module smtg_cordic_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [4:0]      i_stage,
    input  smtg_pkg::t_tag  i_tag,
    input  smtg_pkg::t_cor  i_cor,
    output smtg_pkg::t_tag  o_tag,
    output smtg_pkg::t_cor  o_cor
);
    import smtg_pkg::*;

    t_cor n_cor;
    t_cor r_cor;
    t_tag r_tag;

    always_comb begin
        n_cor = i_cor;
        n_cor.p = rot_step(i_cor.p, i_stage);
        n_cor.t = rot_step(i_cor.t, i_stage);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cor <= n_cor;
    end

    assign o_tag = r_tag;
    assign o_cor = r_cor;

endmodule

/* rtl/core/smtg_vertex_math.sv */
//------------------------------------------------------------------------------
// smtg vertex math
// quadrant fix-up, unit vector products, radius scaling and centre offset
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module smtg_vertex_math (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smtg_pkg::t_tag      i_tag,
    input  smtg_pkg::t_cor      i_cor,
    input  logic [30:0]         i_radius,
    input  logic signed [31:0]  i_center_x,
    input  logic signed [31:0]  i_center_y,
    input  logic signed [31:0]  i_center_z,
    output smtg_pkg::t_tag      o_tag,
    output logic                o_last,
    output logic signed [31:0]  o_x,
    output logic signed [31:0]  o_y,
    output logic signed [31:0]  o_z
);
    import smtg_pkg::*;

    localparam logic signed [63:0] RND64  = 64'sd536870912;
    localparam logic signed [65:0] RND66  = 66'sd536870912;
    localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
    localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

    t_tag r_tag1, r_tag2, r_tag3;
    logic signed [31:0] n_cp, n_sp, n_ct, n_st;
    logic signed [31:0] r_cp, r_sp, r_ct, r_st;
    logic signed [63:0] m_x, m_y;
    logic signed [63:0] s_x, s_y;
    logic signed [31:0] r_ax, r_ay, r_az;
    logic signed [32:0] rad_s;
    logic signed [65:0] m_rx, m_ry, m_rz;
    logic signed [65:0] s_rx, s_ry, s_rz;
    logic signed [33:0] r_rx, r_ry, r_rz;
    logic signed [34:0] sum_x, sum_y, sum_z;
    logic signed [31:0] n_x, n_y, n_z;
    t_tag r_otag;
    logic r_last;
    logic signed [31:0] r_x, r_y, r_z;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // clamp and quadrant swap
    always_comb begin
        logic signed [31:0] c_p, s_p, c_t, s_t;
        c_p = clamp_q30(i_cor.p.x);
        s_p = clamp_q30(i_cor.p.y);
        c_t = clamp_q30(i_cor.t.x);
        s_t = clamp_q30(i_cor.t.y);
        case (i_cor.quad_p)
            2'd0: begin n_cp = c_p;  n_sp = s_p;  end
            2'd1: begin n_cp = -s_p; n_sp = c_p;  end
            2'd2: begin n_cp = -c_p; n_sp = -s_p; end
            default: begin n_cp = s_p; n_sp = -c_p; end
        endcase
        case (i_cor.quad_t)
            2'd0: begin n_ct = c_t;  n_st = s_t;  end
            2'd1: begin n_ct = -s_t; n_st = c_t;  end
            2'd2: begin n_ct = -c_t; n_st = -s_t; end
            default: begin n_ct = s_t; n_st = -c_t; end
        endcase
    end

    // unit vector products in q30
    always_comb begin
        m_x = 64'(r_sp) * 64'(r_ct);
        m_y = 64'(r_sp) * 64'(r_st);
        s_x = (m_x + RND64) >>> 30;
        s_y = (m_y + RND64) >>> 30;
    end

    // radius scaling to q16.16
    always_comb begin
        rad_s = signed'({2'b00, i_radius});
        m_rx = 66'(rad_s) * 66'(r_ax);
        m_ry = 66'(rad_s) * 66'(r_ay);
        m_rz = 66'(rad_s) * 66'(r_az);
        s_rx = (m_rx + RND66) >>> 30;
        s_ry = (m_ry + RND66) >>> 30;
        s_rz = (m_rz + RND66) >>> 30;
    end

    always_comb begin
        sum_x = 35'(r_rx) + 35'(i_center_x);
        sum_y = 35'(r_ry) + 35'(i_center_y);
        sum_z = 35'(r_rz) + 35'(i_center_z);
        if (r_tag3.bad) begin
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end else begin
            n_x = sat32(sum_x);
            n_y = sat32(sum_y);
            n_z = sat32(sum_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_otag <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_otag <= r_tag3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp   <= n_cp;
        r_sp   <= n_sp;
        r_ct   <= n_ct;
        r_st   <= n_st;
        r_ax   <= s_x[31:0];
        r_ay   <= s_y[31:0];
        r_az   <= r_cp;
        r_rx   <= s_rx[33:0];
        r_ry   <= s_ry[33:0];
        r_rz   <= s_rz[33:0];
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_last <= r_tag3.bad || (r_tag3.slot == LAST_SLOT);
    end

    assign o_tag  = r_otag;
    assign o_last = r_last;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

/* rtl/core/sphere_mesh_triangle_generator.sv */
//------------------------------------------------------------------------------
// sphere mesh triangle generator
// turns one latitude-longitude grid cell into the six vertices of its two
// triangles, each vertex computed in a chain of divider and cordic cells
//------------------------------------------------------------------------------
//
//  channel   signals                                   transfer
//  -------   ---------------------------------------   ------------------------
//  cell in   start, busy, i_cell_row, i_cell_col        start && !busy
//  vertex    o_valid, o_vertex_x/y/z, o_corner_slot,    o_valid, one cycle each
//            o_last_vertex, o_bad_cell
//  config    i_cfg_we, i_cfg_idx, i_cfg_data             i_cfg_we
//
//  a cell gives six vertex words: the sequencer issues one vertex word per cycle
//  into the cell chain, and a cell outside the grid or with bad step counts gives
//  one flagged word; each vertex word passes issue, prep, 32 divider cells,
//  cordic prep, 16 cordic cells and 4 math stages
//  busy drops in the cycle that issues a cell's last vertex, so cells stream
//  back to back; a valid cell's vertex words leave in a steady train of 6
//  reset is synchronous and active low; it clears the sequencer and the valid
//  bits of the chain and loads the register defaults
//  the receiver cannot stall: every word is shown for exactly one cycle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sphere_mesh_triangle_generator_defines.svh"

module sphere_mesh_triangle_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          i_cell_row,
    input  logic [7:0]          i_cell_col,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_valid,
    output logic signed [31:0]  o_vertex_x,
    output logic signed [31:0]  o_vertex_y,
    output logic signed [31:0]  o_vertex_z,
    output logic [2:0]          o_corner_slot,
    output logic                o_last_vertex,
    output logic                o_bad_cell
);
    import smtg_pkg::*;

    // configuration registers
    logic [30:0]        r_sphere_radius;
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic signed [31:0] r_center_z;
    logic [STEPS_W-1:0] r_theta_steps;
    logic [STEPS_W-1:0] r_phi_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sphere_radius <= 31'd65536;
            r_center_x      <= '0;
            r_center_y      <= '0;
            r_center_z      <= '0;
            r_theta_steps   <= STEPS_W'(16);
            r_phi_steps     <= STEPS_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS:   r_sphere_radius <= i_cfg_data[30:0];
                REG_CENTER_X: r_center_x      <= signed'(i_cfg_data);
                REG_CENTER_Y: r_center_y      <= signed'(i_cfg_data);
                REG_CENTER_Z: r_center_z      <= signed'(i_cfg_data);
                REG_THETA:    r_theta_steps   <= i_cfg_data[STEPS_W-1:0];
                REG_PHI:      r_phi_steps     <= i_cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // cell sequencer: one vertex word per cycle
    logic       accept;
    logic       n_bad;
    logic       r_active;
    logic       r_bad;
    logic [2:0] r_slot;
    logic [7:0] r_row;
    logic [7:0] r_col;
    logic       seq_end;

    assign seq_end = r_bad || (r_slot == LAST_SLOT);
    assign busy    = r_active && !seq_end;
    assign accept  = start && !busy;

    // out of grid, or step counts that are zero or too large
    always_comb begin
        n_bad = (r_theta_steps == '0) || (r_phi_steps == '0) ||
                (int'(r_theta_steps) > MAX_STEPS) || (int'(r_phi_steps) > MAX_STEPS) ||
                (STEPS_W'(i_cell_row) >= r_phi_steps) ||
                (STEPS_W'(i_cell_col) >= r_theta_steps);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_bad    <= 1'b0;
            r_slot   <= '0;
        end else if (accept) begin
            r_active <= 1'b1;
            r_bad    <= n_bad;
            r_slot   <= '0;
        end else if (r_active) begin
            if (seq_end) begin
                r_active <= 1'b0;
            end else begin
                r_slot <= r_slot + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= i_cell_row;
            r_col <= i_cell_col;
        end
    end

    // issue register: grid point of the current corner
    t_tag               r_iss_tag;
    logic [STEPS_W-1:0] r_iss_r;
    logic [STEPS_W-1:0] r_iss_c;
    logic               row_up;
    logic               col_up;

    // corner order first, second, third, first, third, fourth
    assign row_up = (r_slot inside {3'd1, 3'd2, 3'd4});
    assign col_up = (r_slot inside {3'd2, 3'd4, 3'd5});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_tag <= '0;
        end else begin
            r_iss_tag.valid <= r_active;
            r_iss_tag.bad   <= r_bad;
            r_iss_tag.slot  <= r_bad ? 3'd0 : r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss_r <= STEPS_W'(r_row) + STEPS_W'(row_up);
        r_iss_c <= STEPS_W'(r_col) + STEPS_W'(col_up);
    end

    // prep: split the index into whole turn bit and remainder below the divisor
    t_tag r_prep_tag;
    t_div r_prep;
    logic ge_r;
    logic ge_c;

    assign ge_r = r_iss_r >= r_phi_steps;
    assign ge_c = r_iss_c >= r_theta_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_tag <= '0;
        end else begin
            r_prep_tag <= r_iss_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prep.hi_p  <= ge_r;
        r_prep.hi_t  <= ge_c;
        r_prep.rem_p <= ge_r ? (r_iss_r - r_phi_steps) : r_iss_r;
        r_prep.rem_t <= ge_c ? (r_iss_c - r_theta_steps) : r_iss_c;
        r_prep.q_p   <= '0;
        r_prep.q_t   <= '0;
    end

    // divider chain: one phase bit per cell
    t_tag div_tag [0:DIV_CELLS];
    t_div div_bus [0:DIV_CELLS];

    assign div_tag[0] = r_prep_tag;
    assign div_bus[0] = r_prep;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        smtg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (div_tag[g]),
            .i_div   (div_bus[g]),
            .i_den_p (r_phi_steps),
            .i_den_t (r_theta_steps),
            .o_tag   (div_tag[g+1]),
            .o_div   (div_bus[g+1])
        );
    end

    // cordic prep: phase in 2^-32 turn, shifted by 1/8 turn to find quadrant
    t_div            d_out;
    logic [PH_W-1:0] ph_p;
    logic [PH_W-1:0] ph_t;
    t_tag            r_cp_tag;
    t_cor            r_cp;

    assign d_out = div_bus[DIV_CELLS];
    // polar phase is r * 2^31 / phi_steps: drop one fraction bit
    assign ph_p  = {d_out.hi_p, d_out.q_p[PH_W-1:1]} + 32'h20000000;
    // azimuth whole turn wraps to zero
    assign ph_t  = d_out.q_t + 32'h20000000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_tag <= '0;
        end else begin
            r_cp_tag <= div_tag[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp.quad_p <= ph_p[31:30];
        r_cp.quad_t <= ph_t[31:30];
        r_cp.p.x    <= CORDIC_GAIN;
        r_cp.p.y    <= '0;
        r_cp.p.z    <= signed'({2'b00, ph_p[29:0]}) - 32'sh20000000;
        r_cp.t.x    <= CORDIC_GAIN;
        r_cp.t.y    <= '0;
        r_cp.t.z    <= signed'({2'b00, ph_t[29:0]}) - 32'sh20000000;
    end

    // cordic chain
    t_tag cor_tag [0:CORDIC_STAGES];
    t_cor cor_bus [0:CORDIC_STAGES];

    assign cor_tag[0] = r_cp_tag;
    assign cor_bus[0] = r_cp;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
        smtg_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (5'(g)),
            .i_tag   (cor_tag[g]),
            .i_cor   (cor_bus[g]),
            .o_tag   (cor_tag[g+1]),
            .o_cor   (cor_bus[g+1])
        );
    end

    // vertex arithmetic and output register
    t_tag out_tag;

    smtg_vertex_math u_math (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (cor_tag[CORDIC_STAGES]),
        .i_cor      (cor_bus[CORDIC_STAGES]),
        .i_radius   (r_sphere_radius),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .o_tag      (out_tag),
        .o_last     (o_last_vertex),
        .o_x        (o_vertex_x),
        .o_y        (o_vertex_y),
        .o_z        (o_vertex_z)
    );

    assign o_valid       = out_tag.valid;
    assign o_corner_slot = out_tag.slot;
    assign o_bad_cell    = out_tag.bad;

    // a cell's vertex words leave in one unbroken train with rising slots
    `SMTG_ASSERT_NEXT(a_slot_train, i_clk, i_rst_n, o_valid && !o_last_vertex,
        o_valid && (o_corner_slot == $past(o_corner_slot) + 3'd1),
        "vertex train broken")
    // a flagged cell gives one word with zero coordinates
    `SMTG_ASSERT_IMP(a_bad_word, i_clk, i_rst_n, o_valid && o_bad_cell,
        o_last_vertex && (o_corner_slot == '0) && (o_vertex_x == '0) &&
        (o_vertex_y == '0) && (o_vertex_z == '0),
        "flagged word malformed")
    // the sequencer steps one corner per cycle while a valid cell issues
    `SMTG_ASSERT_NEXT(a_seq_step, i_clk, i_rst_n, r_active && !seq_end,
        r_active && (r_slot == $past(r_slot) + 3'd1),
        "sequencer skipped a corner")
    // an accepted flagged cell frees the input at once
    `SMTG_ASSERT_NEXT(a_bad_free, i_clk, i_rst_n, accept && n_bad,
        !busy && r_bad,
        "flagged cell held the input")

endmodule
